/* rtl/core/cop_pkg.sv */
package cop_pkg;

  // Radius field width is fixed by the interface.
  localparam int unsigned RADIUS_BITS = 5;
  // Offset x runs 0..radius+1, so it needs one bit more than the radius.
  localparam int unsigned OFFSET_BITS = RADIUS_BITS + 1;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;  // capture a new circle and reset the offset
    logic step;  // advance the offset and load the result register
  } cop_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic last;  // the step being taken now ends the walk
  } cop_sts_t;

endpackage

/* rtl/core/cop_datapath.sv */
module cop_datapath #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic                                 clk_i,
  input  cop_pkg::cop_cmd_t                    cmd_i,
  output cop_pkg::cop_sts_t                    sts_o,
  input  logic signed [COORD_BITS-1:0]         center_x_i,
  input  logic signed [COORD_BITS-1:0]         center_y_i,
  input  logic        [cop_pkg::RADIUS_BITS-1:0] radius_i,
  output logic signed [COORD_BITS-1:0]         p0_x_o,
  output logic signed [COORD_BITS-1:0]         p0_y_o,
  output logic signed [COORD_BITS-1:0]         p1_x_o,
  output logic signed [COORD_BITS-1:0]         p1_y_o,
  output logic signed [COORD_BITS-1:0]         p2_x_o,
  output logic signed [COORD_BITS-1:0]         p2_y_o,
  output logic signed [COORD_BITS-1:0]         p3_x_o,
  output logic signed [COORD_BITS-1:0]         p3_y_o,
  output logic                                 last_step_o
);
  import cop_pkg::*;

  localparam int unsigned SQ_W  = 2 * OFFSET_BITS + 1;
  localparam int unsigned RSQ_W = 2 * RADIUS_BITS;

  // Held circle and walk offset. y is kept as its magnitude: y = -ym.
  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [RADIUS_BITS-1:0] r_q, r_sat;
  logic [RSQ_W-1:0]       rsq_q;
  logic [OFFSET_BITS-1:0] x_q, x_d;
  logic [RADIUS_BITS-1:0] ym_q, ym_d;
  logic [SQ_W-1:0]        sq_sum;
  logic                   go_y;

  // Result register.
  logic [COORD_BITS-1:0]  p0x_q, p0y_q, p1y_q, p2x_q;
  logic                   last_q;
  logic [COORD_BITS-1:0]  xe_d, ye_d;

  assign r_sat = (radius_i > RADIUS_BITS'(MAX_RADIUS)) ? RADIUS_BITS'(MAX_RADIUS) : radius_i;

  assign sq_sum = SQ_W'(x_q) * SQ_W'(x_q) + SQ_W'(ym_q) * SQ_W'(ym_q);
  assign go_y   = sq_sum > SQ_W'(rsq_q);
  assign x_d    = go_y ? x_q : x_q + OFFSET_BITS'(1);
  assign ym_d   = go_y ? ym_q - RADIUS_BITS'(1) : ym_q;

  assign sts_o.last = x_d > OFFSET_BITS'(r_q);

  assign xe_d = COORD_BITS'(x_d);
  assign ye_d = COORD_BITS'(ym_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      r_q   <= r_sat;
      rsq_q <= RSQ_W'(r_sat) * RSQ_W'(r_sat);
      x_q   <= '0;
      ym_q  <= r_sat;
    end else if (cmd_i.step) begin
      x_q  <= x_d;
      ym_q <= ym_d;
    end
    if (cmd_i.step) begin
      p0x_q  <= cx_q + xe_d - COORD_BITS'(1);
      p2x_q  <= cx_q - xe_d;
      p0y_q  <= cy_q - ye_d;
      p1y_q  <= cy_q + ye_d;
      last_q <= sts_o.last;
    end
  end

  assign p0_x_o      = p0x_q;
  assign p1_x_o      = p0x_q;
  assign p2_x_o      = p2x_q;
  assign p3_x_o      = p2x_q;
  assign p0_y_o      = p0y_q;
  assign p2_y_o      = p0y_q;
  assign p1_y_o      = p1y_q;
  assign p3_y_o      = p1y_q;
  assign last_step_o = last_q;

endmodule

/* rtl/core/cop_ctrl.sv */
module cop_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cop_pkg::cop_cmd_t cmd_o,
  input  cop_pkg::cop_sts_t sts_i
);
  import cop_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  // In the walk, step whenever the result register is empty or being drained.
  assign cmd_o.step = (state_q == ST_WALK) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cmd_o.step) begin
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/circle_outline_points.sv */
// Circle outline point generator. Each input transaction carries one circle
// (center_x, center_y, radius 0..31; radii above MAX_RADIUS are clamped).
// The block walks an offset (x, y) from (0, -radius): when x*x+y*y exceeds
// radius squared y steps up, otherwise x steps up, and after every step one
// output transaction carries four mirrored points (cx+x-1, cy+/-y) and
// (cx-x, cy+/-y). A circle yields 2*radius+1 output transactions, the final
// one with last_step_o set; all coordinates wrap modulo 2^COORD_BITS.
// Flow: the circle is captured first, then the walk issues one result per
// cycle when the output is never stalled. The walk is a single step unit
// with one output register; it advances only when that register is empty
// or being taken, so output stall holds the walk. A new circle is taken
// only once the previous walk has issued its last step; the last result may
// still sit in the output register at that time.
module circle_outline_points #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // circle input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [COORD_BITS-1:0]           center_x_i,
  input  logic signed [COORD_BITS-1:0]           center_y_i,
  input  logic        [cop_pkg::RADIUS_BITS-1:0] radius_i,
  // point output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [COORD_BITS-1:0]           p0_x_o,
  output logic signed [COORD_BITS-1:0]           p0_y_o,
  output logic signed [COORD_BITS-1:0]           p1_x_o,
  output logic signed [COORD_BITS-1:0]           p1_y_o,
  output logic signed [COORD_BITS-1:0]           p2_x_o,
  output logic signed [COORD_BITS-1:0]           p2_y_o,
  output logic signed [COORD_BITS-1:0]           p3_x_o,
  output logic signed [COORD_BITS-1:0]           p3_y_o,
  output logic                                   last_step_o
);
  import cop_pkg::*;

  cop_cmd_t cmd;
  cop_sts_t sts;

  // Sequencer: owns the handshakes and the result-valid flag.
  cop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Step unit: held circle, offset, distance compare, result register.
  cop_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .p0_x_o      (p0_x_o),
    .p0_y_o      (p0_y_o),
    .p1_x_o      (p1_x_o),
    .p1_y_o      (p1_y_o),
    .p2_x_o      (p2_x_o),
    .p2_y_o      (p2_y_o),
    .p3_x_o      (p3_x_o),
    .p3_y_o      (p3_y_o),
    .last_step_o (last_step_o)
  );

endmodule

/* rtl/core/cop_checker.sv */
module cop_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [COORD_BITS-1:0]           p0_x_o,
  input logic signed [COORD_BITS-1:0]           p0_y_o,
  input logic signed [COORD_BITS-1:0]           p1_x_o,
  input logic signed [COORD_BITS-1:0]           p1_y_o,
  input logic signed [COORD_BITS-1:0]           p2_x_o,
  input logic signed [COORD_BITS-1:0]           p2_y_o,
  input logic signed [COORD_BITS-1:0]           p3_x_o,
  input logic signed [COORD_BITS-1:0]           p3_y_o,
  input logic                                   last_step_o
);

  // Stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(p0_x_o) && $stable(p0_y_o)
      && $stable(p3_x_o) && $stable(p3_y_o) && $stable(last_step_o))
    else $error("stalled result changed");

  // A captured circle always keeps the input side busy for the walk.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input free right after circle capture");

  // A non-final result means the walk is still running.
  a_mid_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_step_o |-> in_stall_o)
    else $error("non-final result while idle");

  // Mirrored points share their coordinates pairwise.
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (p0_x_o == p1_x_o) && (p2_x_o == p3_x_o)
      && (p0_y_o == p2_y_o) && (p1_y_o == p3_y_o))
    else $error("mirrored points disagree");

endmodule

bind circle_outline_points cop_checker #(.COORD_BITS(COORD_BITS)) u_cop_checker (.*);
